@@ rtl/core/bmp24_pkg.sv @@
// Shared types and constants for the BMP 24-bit stream decoder.
package bmp24_pkg;

    localparam int DIM_BITS_DEF = 16;

    // Result status codes
    localparam logic [3:0] ST_PIXEL  = 4'd0;
    localparam logic [3:0] ST_DONE   = 4'd1;
    localparam logic [3:0] ST_SIG    = 4'd2;
    localparam logic [3:0] ST_HSIZE  = 4'd3;
    localparam logic [3:0] ST_WIDTH  = 4'd4;
    localparam logic [3:0] ST_HEIGHT = 4'd5;
    localparam logic [3:0] ST_PLANES = 4'd6;
    localparam logic [3:0] ST_BPP    = 4'd7;
    localparam logic [3:0] ST_COMP   = 4'd8;
    localparam logic [3:0] ST_OFFSET = 4'd9;
    localparam logic [3:0] ST_TRUNC  = 4'd10;
    localparam logic [3:0] ST_LARGE  = 4'd11;

    // Header byte positions of the checked fields
    localparam logic [5:0] POS_SIG    = 6'd1;
    localparam logic [5:0] POS_OFFSET = 6'd13;
    localparam logic [5:0] POS_HSIZE  = 6'd17;
    localparam logic [5:0] POS_WIDTH  = 6'd21;
    localparam logic [5:0] POS_HEIGHT = 6'd25;
    localparam logic [5:0] POS_PLANES = 6'd27;
    localparam logic [5:0] POS_BPP    = 6'd29;
    localparam logic [5:0] POS_LAST   = 6'd33;

    localparam logic [15:0] SIG_WORD = 16'h4D42;
    localparam logic [31:0] DIB_SIZE = 32'd40;
    localparam logic [15:0] BPP_24   = 16'd24;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_PIXEL  = 2'd2,
        PH_IDLE   = 2'd3
    } t_phase;

    // One result beat, output width of fields
    typedef struct packed {
        logic        final_result;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [15:0] column_index;
        logic [15:0] row_index;
        logic [3:0]  status;
    } t_result;

    localparam int RES_W = $bits(t_result);

    // Front-to-back queue entry: up to two results per input byte
    typedef struct packed {
        logic    two;
        t_result r1;
        t_result r0;
    } t_qentry;

endpackage

@@ rtl/core/bmp24_front.sv @@
// Front part: parses the header and pixel bytes, builds up to two results per byte.
module bmp24_front #(
    parameter int DIM_BITS = bmp24_pkg::DIM_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_file,
    output logic               o_q_valid,
    output bmp24_pkg::t_qentry o_q_entry,
    input  logic               i_q_ready
);
    import bmp24_pkg::*;

    localparam logic [31:0] DIM_MAX = 32'((64'd1 << DIM_BITS) - 64'd1);
    localparam int BR_W = DIM_BITS + 3;   // byte_in_row covers 4*width

    t_phase               r_phase, n_phase;
    logic [5:0]           r_pos, n_pos;          // header byte position
    logic [31:0]          r_shift, n_shift;
    logic [31:0]          r_off, n_off;
    logic [31:0]          r_skip, n_skip;        // file bytes consumed so far, in skip
    logic [DIM_BITS-1:0]  r_width, n_width;
    logic [DIM_BITS-1:0]  r_height, n_height;
    logic                 r_bu, n_bu;
    logic [DIM_BITS-1:0]  r_row, n_row;
    logic [DIM_BITS-1:0]  r_col, n_col;
    logic [1:0]           r_k, n_k;              // byte in triple
    logic [BR_W-1:0]      r_bir, n_bir;
    logic [BR_W-1:0]      r_rowb, n_rowb;        // 3*width
    logic [BR_W-1:0]      r_stride, n_stride;
    logic [15:0]          r_bg, n_bg;

    logic                 acc;
    logic [31:0]          v, mag;
    logic [3:0]           err;
    logic                 pix, done;
    logic [DIM_BITS-1:0]  row_out;
    t_result              pres, fres;
    logic                 fin_q;
    logic [3:0]           fin_st;
    logic [BR_W-1:0]      w3;

    assign o_ready = i_q_ready;
    assign acc     = i_valid & o_ready;
    assign w3      = BR_W'(r_width) + BR_W'({r_width, 1'b0});

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_shift = r_shift; n_off = r_off;
        n_skip = r_skip; n_width = r_width; n_height = r_height; n_bu = r_bu;
        n_row = r_row; n_col = r_col; n_k = r_k; n_bir = r_bir; n_bg = r_bg;
        n_rowb = r_rowb; n_stride = r_stride;
        v = {i_data_byte, r_shift[31:8]};
        mag = v[31] ? (~v + 32'd1) : v;
        err = ST_PIXEL; pix = 1'b0; done = 1'b0;
        row_out = r_bu ? (r_height - DIM_BITS'(1) - r_row) : r_row;
        unique case (r_phase)
            PH_HEADER: begin
                n_shift = v;
                n_pos = r_pos + 6'd1;
                unique case (r_pos)
                    POS_SIG:    if (v[31:16] != SIG_WORD) err = ST_SIG;
                    POS_OFFSET: n_off = v;
                    POS_HSIZE:  if (v != DIB_SIZE) err = ST_HSIZE;
                    POS_WIDTH: begin
                        if (v == 32'd0 || v[31]) err = ST_WIDTH;
                        else if (v > DIM_MAX) err = ST_LARGE;
                        else n_width = v[DIM_BITS-1:0];
                    end
                    POS_HEIGHT: begin
                        if (v == 32'd0) err = ST_HEIGHT;
                        else if (mag > DIM_MAX) err = ST_LARGE;
                        else begin
                            n_height = mag[DIM_BITS-1:0];
                            n_bu = ~v[31];
                        end
                    end
                    POS_PLANES: if (v[31:16] != 16'd1) err = ST_PLANES;
                    POS_BPP:    if (v[31:16] != BPP_24) err = ST_BPP;
                    POS_LAST: begin
                        if (v != 32'd0) err = ST_COMP;
                        else if (r_off < 32'd34) err = ST_OFFSET;
                        else begin
                            n_row = '0; n_col = '0; n_k = '0; n_bir = '0;
                            n_rowb = w3;
                            n_stride = (w3 + BR_W'(3)) & ~BR_W'(3);
                            n_skip = 32'd34;
                            n_phase = (r_off == 32'd34) ? PH_PIXEL : PH_SKIP;
                        end
                    end
                    default: ;
                endcase
                if (err != ST_PIXEL) n_phase = PH_IDLE;
            end
            PH_SKIP: begin
                n_skip = r_skip + 32'd1;
                if (n_skip == r_off) n_phase = PH_PIXEL;
            end
            PH_PIXEL: begin
                if (r_bir < r_rowb) begin
                    case (r_k)
                        2'd0: n_bg[7:0] = i_data_byte;
                        2'd1: n_bg[15:8] = i_data_byte;
                        default: pix = 1'b1;
                    endcase
                    n_k = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    if (r_k == 2'd2) n_col = r_col + DIM_BITS'(1);
                end
                n_bir = r_bir + BR_W'(1);
                if (n_bir >= r_stride) begin
                    n_bir = '0; n_k = '0; n_col = '0;
                    n_row = r_row + DIM_BITS'(1);
                    if (n_row >= r_height) begin
                        done = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_IDLE: ;
            default: ;
        endcase
        if (i_end_of_file) begin
            n_phase = PH_HEADER; n_pos = '0; n_shift = '0; n_off = '0;
            n_skip = '0; n_width = '0; n_height = '0; n_bu = 1'b0;
            n_row = '0; n_col = '0; n_k = '0; n_bir = '0; n_bg = '0;
        end
    end

    // Assemble the results of this byte
    always_comb begin
        pres = '0;
        pres.status = ST_PIXEL;
        pres.row_index = 16'(row_out);
        pres.column_index = 16'(r_col);
        pres.red = i_data_byte;
        pres.green = r_bg[15:8];
        pres.blue = r_bg[7:0];
        fin_q = 1'b0; fin_st = ST_DONE;
        if (err != ST_PIXEL) begin
            fin_q = 1'b1; fin_st = err;
        end else if (done) begin
            fin_q = 1'b1; fin_st = ST_DONE;
        end else if (i_end_of_file && r_phase != PH_IDLE) begin
            fin_q = 1'b1; fin_st = ST_TRUNC;
        end
        fres = '0;
        fres.status = fin_st;
        fres.final_result = 1'b1;
        o_q_entry = '0;
        o_q_entry.two = pix & fin_q;
        o_q_entry.r0 = pix ? pres : fres;
        o_q_entry.r1 = fres;
        o_q_valid = acc & (pix | fin_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_pos <= '0; r_shift <= '0; r_off <= '0;
            r_skip <= '0; r_width <= '0; r_height <= '0; r_bu <= 1'b0;
            r_row <= '0; r_col <= '0; r_k <= '0; r_bir <= '0; r_bg <= '0;
            r_rowb <= '0; r_stride <= '0;
        end else if (acc) begin
            r_phase <= n_phase; r_pos <= n_pos; r_shift <= n_shift; r_off <= n_off;
            r_skip <= n_skip; r_width <= n_width; r_height <= n_height; r_bu <= n_bu;
            r_row <= n_row; r_col <= n_col; r_k <= n_k; r_bir <= n_bir; r_bg <= n_bg;
            r_rowb <= n_rowb; r_stride <= n_stride;
        end
    end

    // Header position never passes the last header byte while parsing
    a_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HEADER |-> r_pos <= POS_LAST)
        else $error("header position overrun");
    // Triple counter stays in range
    a_k: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_k != 2'd3)
        else $error("triple counter out of range");
    // Entry is only produced when the queue takes it
    a_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_valid |-> i_q_ready)
        else $error("queue write while full");

endmodule

@@ rtl/core/bmp24_back.sv @@
// Back part: a two-entry queue of result pairs and the output stage.
module bmp24_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  bmp24_pkg::t_qentry i_q_entry,
    output logic               o_q_ready,
    output logic               o_valid,
    output bmp24_pkg::t_result o_result,
    input  logic               i_ready
);
    import bmp24_pkg::*;

    t_qentry    r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       r_sub;        // second result of head entry pending
    logic       pop, push;
    t_qentry    head;

    assign head      = r_q[r_rp];
    assign o_valid   = (r_cnt != 2'd0);
    assign o_result  = r_sub ? head.r1 : head.r0;
    assign pop       = o_valid & i_ready & (r_sub | ~head.two);
    assign o_q_ready = (r_cnt != 2'd2);
    assign push      = i_q_valid & o_q_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_q_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_sub <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            if (o_valid && i_ready) r_sub <= ~pop;
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub |-> (r_cnt != 2'd0))
        else $error("second half pending on empty queue");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result dropped while stalled");

endmodule

@@ rtl/core/bmp24_stream_decoder_unit.sv @@
// Top level of the BMP 24-bit uncompressed stream decoder.
//
//  Channel  Dir  Payload
//  s_axis   in   tdata = data_byte, tlast = end_of_file
//  m_axis   out  tdata = status,row_index,column_index,red,green,blue; tlast = final_result
//
//  One file byte per clock when the result side keeps up.
//  A byte making a pixel plus a final status gives two beats; the two-entry
//  queue between parser and output absorbs them, ready drops when it is full.
//  Reset is synchronous, active low, and rearms the parser at the signature.
//  Either side may stall at any cycle without loss.
module bmp24_stream_decoder_unit #(
    parameter int DIM_BITS = bmp24_pkg::DIM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] status, [19:4] row_index, [35:20] column_index,
    // [43:36] red, [51:44] green, [59:52] blue, [63:60] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import bmp24_pkg::*;

    logic    q_valid, q_ready;
    t_qentry q_entry;
    t_result res;

    bmp24_front #(.DIM_BITS(DIM_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data_byte(s_axis_tdata), .i_end_of_file(s_axis_tlast),
        .o_q_valid(q_valid), .o_q_entry(q_entry), .i_q_ready(q_ready)
    );

    bmp24_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_entry(q_entry), .o_q_ready(q_ready),
        .o_valid(m_axis_tvalid), .o_result(res), .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, res.blue, res.green, res.red, res.column_index,
                           res.row_index, res.status};
    assign m_axis_tlast = res.final_result;

endmodule

@@ sim/bmp24_stream_decoder_unit_test.sv @@
// Self-checking testbench for the BMP 24-bit stream decoder: header, pixel and error paths.
module bmp24_stream_decoder_unit_test;
    import bmp24_pkg::*;

    localparam int DIMB = 16;
    localparam int CYCLE_LIMIT = 2000000;

    // Expected pixel/status beat
    typedef struct {
        logic [3:0]  status;
        logic [15:0] row_index;
        logic [15:0] column_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        final_result;
    } t_pix_beat;

    // Scoreboard: decoder predictor plus queue of pending beats
    class bmp_scoreboard;
        t_pix_beat   pending[$];
        int          fail_count;
        t_phase      ph;
        logic [31:0] pos, shreg, offs;
        logic [31:0] wid, hgt;
        logic        flip_rows;
        logic [31:0] rows_done;
        logic [31:0] row_byte;
        logic [15:0] bg_hold;

        function void rearm();
            ph = PH_HEADER;
            pos = 0; shreg = 0; offs = 0; wid = 0; hgt = 0;
            flip_rows = 0; rows_done = 0; row_byte = 0; bg_hold = 0;
        endfunction

        function void push(logic [3:0] st, logic [15:0] r, logic [15:0] c,
                           logic [7:0] rd, logic [7:0] gr, logic [7:0] bl, logic fin);
            t_pix_beat e;
            e.status = st; e.row_index = r; e.column_index = c;
            e.red = rd; e.green = gr; e.blue = bl; e.final_result = fin;
            pending.push_back(e);
        endfunction

        // Predict the beats caused by one accepted byte
        function void note_byte(logic [7:0] b, logic eof);
            logic [3:0]  err;
            logic [31:0] v, mag, rowb, stride, rw;
            logic [31:0] dmax;
            err = ST_PIXEL;
            dmax = (32'd1 << DIMB) - 1;
            if (ph == PH_HEADER) begin
                shreg = (shreg >> 8) | ({24'd0, b} << 24);
                v = shreg;
                case (pos)
                    32'd1:  if (v[31:16] != SIG_WORD) err = ST_SIG;
                    32'd13: offs = v;
                    32'd17: if (v != DIB_SIZE) err = ST_HSIZE;
                    32'd21: begin
                        if (v == 0 || v[31]) err = ST_WIDTH;
                        else if (v > dmax) err = ST_LARGE;
                        else wid = v;
                    end
                    32'd25: begin
                        mag = v[31] ? (~v + 1) : v;
                        if (v == 0) err = ST_HEIGHT;
                        else if (mag > dmax) err = ST_LARGE;
                        else begin
                            hgt = mag;
                            flip_rows = !v[31];
                        end
                    end
                    32'd27: if (v[31:16] != 16'd1) err = ST_PLANES;
                    32'd29: if (v[31:16] != BPP_24) err = ST_BPP;
                    32'd33: begin
                        if (v != 0) err = ST_COMP;
                        else if (offs < 34) err = ST_OFFSET;
                        else begin
                            rows_done = 0;
                            row_byte = 0;
                            ph = (offs == 34) ? PH_PIXEL : PH_SKIP;
                        end
                    end
                    default: ;
                endcase
                pos = pos + 1;
                if (err != ST_PIXEL) begin
                    push(err, 0, 0, 0, 0, 0, 1);
                    ph = PH_IDLE;
                end
            end else if (ph == PH_SKIP) begin
                pos = pos + 1;
                if (pos == offs) ph = PH_PIXEL;
            end else if (ph == PH_PIXEL) begin
                rowb = wid * 3;
                stride = (rowb + 3) & ~32'd3;
                if (row_byte < rowb) begin
                    case (row_byte % 3)
                        0: bg_hold[7:0] = b;
                        1: bg_hold[15:8] = b;
                        default: begin
                            rw = flip_rows ? (hgt - 1 - rows_done) : rows_done;
                            push(ST_PIXEL, rw[15:0], 16'(row_byte / 3), b,
                                 bg_hold[15:8], bg_hold[7:0], 0);
                        end
                    endcase
                end
                row_byte = row_byte + 1;
                if (row_byte >= stride) begin
                    row_byte = 0;
                    rows_done = rows_done + 1;
                    if (rows_done >= hgt) begin
                        push(ST_DONE, 0, 0, 0, 0, 0, 1);
                        ph = PH_IDLE;
                    end
                end
            end
            if (eof) begin
                if (ph != PH_IDLE) push(ST_TRUNC, 0, 0, 0, 0, 0, 1);
                rearm();
            end
        endfunction

        function void cmp(string name, logic [15:0] e, logic [15:0] a);
            if (e !== a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                fail_count++;
            end
        endfunction

        // Compare one result beat with the oldest expectation
        function void check_beat(logic [63:0] d, logic last);
            t_pix_beat e;
            if (pending.size() == 0) begin
                $error("unexpected result beat: tdata %h", d);
                fail_count++;
                return;
            end
            e = pending.pop_front();
            cmp("status", 16'(e.status), 16'(d[3:0]));
            cmp("row_index", e.row_index, d[19:4]);
            cmp("column_index", e.column_index, d[35:20]);
            cmp("red", 16'(e.red), 16'(d[43:36]));
            cmp("green", 16'(e.green), 16'(d[51:44]));
            cmp("blue", 16'(e.blue), 16'(d[59:52]));
            cmp("final_result", 16'(e.final_result), 16'(last));
            cmp("pad", 16'd0, 16'(d[63:60]));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // end_of_file
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // status,row,col,red,green,blue from bit 0 up
    logic        m_axis_tlast;   // final_result

    bmp_scoreboard sb;
    int unsigned   cycles;
    logic [7:0]    file_buf[$];
    int            bytes_sent;
    bit            rx_stall_mode;

    bmp24_stream_decoder_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: check accepted beats, stall on a pattern of bursts
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast);
        if (rx_stall_mode)
            m_axis_tready <= ($urandom_range(0, 3) != 0) && (cycles % 37 > 4);
        else
            m_axis_tready <= 1'b1;
    end

    // Send one byte; holds valid until accepted
    task automatic send_byte(logic [7:0] b, logic eof);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eof;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_byte(b, eof);
        bytes_sent++;
    endtask

    // Send the assembled file with random bursts and gaps
    task automatic send_file();
        int burst;
        int gap;
        burst = $urandom_range(1, 20);
        foreach (file_buf[i]) begin
            send_byte(file_buf[i], i == file_buf.size() - 1);
            burst--;
            if (burst == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst = $urandom_range(1, 20);
            end
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put_le(int n, logic [31:0] v);
        for (int k = 0; k < n; k++) file_buf.push_back(v[8*k +: 8]);
    endtask

    // Build a file: header fields, optional gap, pixel bytes; trunc cuts the length
    task automatic build_file(logic [15:0] sig, logic [31:0] offs, logic [31:0] hsize,
                              logic [31:0] w, logic [31:0] h, logic [15:0] planes,
                              logic [15:0] bpp, logic [31:0] comp, int trunc,
                              int extra);
        int nbody;
        int stride;
        int absh;
        file_buf.delete();
        put_le(2, {16'd0, sig});
        for (int k = 0; k < 8; k++) file_buf.push_back(8'($urandom));
        put_le(4, offs);
        put_le(4, hsize);
        put_le(4, w);
        put_le(4, h);
        put_le(2, {16'd0, planes});
        put_le(2, {16'd0, bpp});
        put_le(4, comp);
        if (offs >= 34 && offs < 200)
            for (int k = 34; k < offs; k++) file_buf.push_back(8'($urandom));
        stride = ((w * 3) + 3) & ~3;
        absh = h[31] ? -h : h;
        nbody = (w < 64 && absh < 64) ? stride * absh : 8;
        for (int k = 0; k < nbody + extra; k++) file_buf.push_back(8'($urandom));
        while (trunc > 0 && file_buf.size() > 1) begin
            void'(file_buf.pop_back());
            trunc--;
        end
    endtask

    task automatic good_file(logic [31:0] w, logic [31:0] h, logic [31:0] offs,
                             int trunc, int extra);
        build_file(SIG_WORD, offs, DIB_SIZE, w, h, 16'd1, BPP_24, 0, trunc, extra);
        send_file();
    endtask

    initial begin
        int pick;
        int w;
        int h;
        sb = new();
        sb.rearm();
        sb.fail_count = 0;
        cycles = 0;
        bytes_sent = 0;
        rx_stall_mode = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: good images both row orders, then each error code
        good_file(2, 2, 34, 0, 0);
        good_file(1, -3, 40, 0, 0);
        good_file(3, 1, 34, 0, 3);
        good_file(2, 2, 34, 3, 0);
        build_file(16'h4D43, 34, 40, 1, 1, 1, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 41, 1, 1, 1, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 0, 1, 1, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 32'h8000_0000, 1, 1, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 65536, 1, 1, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 1, 0, 1, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 1, 32'h8000_0000, 1, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 1, 32'hFFFF_0000, 1, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 1, 1, 2, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 1, 1, 1, 32, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 1, 1, 1, 24, 32'hFFFF_FFFF, 0, 0); send_file();
        build_file(SIG_WORD, 33, 40, 1, 1, 1, 24, 0, 0, 0); send_file();
        build_file(SIG_WORD, 34, 40, 65535, 1, 1, 24, 0, 20, 0); send_file();
        build_file(SIG_WORD, 34, 40, 1, 65535, 1, 24, 0, 20, 0); send_file();
        send_byte(8'h42, 1'b1);
        send_byte(8'hFF, 1'b1);

        // Random: mostly well-formed files, some broken or truncated
        rx_stall_mode = 1;
        while (bytes_sent < 850) begin
            if (($urandom_range(0, 3)) == 0) rx_stall_mode = !rx_stall_mode;
            pick = $urandom_range(0, 9);
            w = $urandom_range(1, 7);
            h = $urandom_range(1, 5);
            if ($urandom_range(0, 1)) h = -h;
            if (pick < 6)
                good_file(w, h, $urandom_range(34, 44), 0, $urandom_range(0, 2));
            else if (pick < 8)
                good_file(w, h, 34, $urandom_range(1, 20), 0);
            else begin
                build_file(16'($urandom), $urandom, $urandom_range(0, 1) ? 40 : $urandom,
                           $urandom, $urandom, 16'($urandom_range(0, 1) ? 1 : $urandom),
                           16'($urandom_range(0, 1) ? 24 : $urandom),
                           $urandom_range(0, 1) ? 0 : $urandom, 0, 0);
                send_file();
            end
        end

        // Drain
        rx_stall_mode = 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ bmp24_stream_decoder_unit.f @@
rtl/core/bmp24_pkg.sv
rtl/core/bmp24_front.sv
rtl/core/bmp24_back.sv
rtl/core/bmp24_stream_decoder_unit.sv
sim/bmp24_stream_decoder_unit_test.sv
